### rtl/ncff_pkg.sv
// shared types, register indexes, status codes and policy constants for the cpuid filter
package ncff_pkg;

  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned OUT_DATA_W = 136;

  // configuration register indexes
  localparam logic [2:0] REG_XSTATE_READY    = 3'd0;
  localparam logic [2:0] REG_USER_STATE_MASK = 3'd1;
  localparam logic [2:0] REG_SUPV_STATE_MASK = 3'd2;
  localparam logic [2:0] REG_EXPOSE_SVM      = 3'd3;
  localparam logic [2:0] REG_SVM_FEATURES    = 3'd4;
  localparam logic [2:0] REG_ASID_COUNT      = 3'd5;
  localparam logic [2:0] REG_CR4_ALLOWED     = 3'd6;
  localparam logic [2:0] REG_PHYS_ADDR_BITS  = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_XSTATE = 2'd2;

  // leaves
  localparam logic [31:0] LEAF_FEATURES   = 32'h0000_0001;
  localparam logic [31:0] LEAF_STRUCTURED = 32'h0000_0007;
  localparam logic [31:0] LEAF_XSTATE     = 32'h0000_000d;
  localparam logic [31:0] LEAF_EXT_FEAT   = 32'h8000_0001;
  localparam logic [31:0] LEAF_SVM        = 32'h8000_000a;
  localparam logic [31:0] LEAF_ADDR_SIZE  = 32'h8000_0008;
  localparam logic [31:0] LEAF_MEM_ENC    = 32'h8000_001f;

  localparam logic [31:0] SVM_FEATURE_ALLOW_MASK = 32'h0000_0009;
  localparam logic [31:0] SVM_REQUIRED_BITS      = 32'h0000_0009;
  localparam logic [63:0] AVX_STATE              = 64'h0000_0000_0000_0006;
  localparam logic [63:0] AVX512_STATE           = 64'h0000_0000_0000_00e7;
  localparam logic [31:0] AVX512_EBX_BITS        = 32'hdc23_0000;
  localparam logic [31:0] ADDR_KEEP_MASK         = 32'hff00_0000;
  localparam logic [7:0]  LINEAR_BITS            = 8'd48;
  localparam logic [7:0]  PHYS_BITS_MIN          = 8'd32;
  localparam logic [7:0]  PHYS_BITS_MAX          = 8'd48;
  localparam logic [7:0]  PHYS_BITS_RESET        = 8'd48;

  typedef struct packed {
    logic        xstate_ready;
    logic [63:0] user_state_mask;
    logic [63:0] supervisor_state_mask;
    logic        expose_svm;
    logic [31:0] svm_feature_bits;
    logic [31:0] asid_count;
    logic [63:0] cr4_allowed;
    logic [7:0]  phys_addr_bits;
  } cfg_t;

  typedef struct packed {
    logic [31:0] leaf;
    logic [31:0] subleaf;
    logic [63:0] guest_cr4;
    logic [31:0] raw_eax;
    logic [31:0] raw_ebx;
    logic [31:0] raw_ecx;
    logic [31:0] raw_edx;
  } query_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_eax;
    logic [31:0] out_ebx;
    logic [31:0] out_ecx;
    logic [31:0] out_edx;
  } result_t;

endpackage

### rtl/ncff_cfg_regs.sv
// policy register file written through the configuration channel
module ncff_cfg_regs
  import ncff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.xstate_ready          <= 1'b0;
      regs.user_state_mask       <= '0;
      regs.supervisor_state_mask <= '0;
      regs.expose_svm            <= 1'b0;
      regs.svm_feature_bits      <= '0;
      regs.asid_count            <= '0;
      regs.cr4_allowed           <= '0;
      regs.phys_addr_bits        <= PHYS_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_XSTATE_READY:    regs.xstate_ready          <= cfg_data[0];
        REG_USER_STATE_MASK: regs.user_state_mask       <= cfg_data;
        REG_SUPV_STATE_MASK: regs.supervisor_state_mask <= cfg_data;
        REG_EXPOSE_SVM:      regs.expose_svm            <= cfg_data[0];
        REG_SVM_FEATURES:    regs.svm_feature_bits      <= cfg_data[31:0];
        REG_ASID_COUNT:      regs.asid_count            <= cfg_data[31:0];
        REG_CR4_ALLOWED:     regs.cr4_allowed           <= cfg_data;
        REG_PHYS_ADDR_BITS:  regs.phys_addr_bits        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/ncff_filter.sv
// per-leaf feature masking of one cpuid query against the policy registers
module ncff_filter
  import ncff_pkg::*;
(
  input  cfg_t    cfg,
  input  query_t  q,
  output result_t r
);

  logic        svm_ok;
  logic        svm_bad;
  logic        avx_ok;
  logic        avx512_ok;
  logic        addr_ok;
  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] w2;
  logic [31:0] w3;
  logic [1:0]  st;
  logic        zero;

  assign svm_ok    = cfg.expose_svm && (cfg.asid_count >= 32'd2);
  assign svm_bad   = cfg.expose_svm &&
                     (((cfg.svm_feature_bits & SVM_REQUIRED_BITS) != SVM_REQUIRED_BITS) ||
                      (cfg.asid_count < 32'd2));
  assign avx_ok    = (cfg.user_state_mask & AVX_STATE) == AVX_STATE;
  assign avx512_ok = (cfg.user_state_mask & AVX512_STATE) == AVX512_STATE;
  assign addr_ok   = (cfg.phys_addr_bits >= PHYS_BITS_MIN) &&
                     (cfg.phys_addr_bits <= PHYS_BITS_MAX);

  always_comb begin
    w0   = q.raw_eax;
    w1   = q.raw_ebx;
    w2   = q.raw_ecx;
    w3   = q.raw_edx;
    st   = ST_OK;
    zero = 1'b0;
    if (!cfg.xstate_ready || svm_bad) begin
      st   = ST_REJECT;
      zero = 1'b1;
    end else if (q.leaf == LEAF_XSTATE) begin
      st   = ST_XSTATE;
      zero = 1'b1;
    end else begin
      case (q.leaf)
        LEAF_FEATURES: begin
          // osxsave mirrors the guest cr4
          w2[27] = q.guest_cr4[18];
          if (!avx_ok) begin
            w2[28] = 1'b0;
            w2[12] = 1'b0;
            w2[29] = 1'b0;
          end
          if (!cfg.cr4_allowed[17]) w2[17] = 1'b0;
        end
        LEAF_STRUCTURED: begin
          if (q.subleaf != 32'd0) begin
            zero = 1'b1;
          end else begin
            w0 = '0;
            if (!avx_ok) w1[5] = 1'b0;
            if (!avx512_ok) begin
              w1 = w1 & ~AVX512_EBX_BITS;
              w2[1]  = 1'b0;
              w2[6]  = 1'b0;
              w2[11] = 1'b0;
              w2[12] = 1'b0;
              w2[14] = 1'b0;
              w3[2]  = 1'b0;
              w3[3]  = 1'b0;
              w3[8]  = 1'b0;
              w3[23] = 1'b0;
            end
            w2[3]  = 1'b0;
            w2[4]  = 1'b0;
            w2[16] = 1'b0;
            w2[31] = 1'b0;
            w3[5]  = 1'b0;
            w3[20] = 1'b0;
            w1[14] = 1'b0;
            w3[22] = 1'b0;
            w3[24] = 1'b0;
            w3[25] = 1'b0;
            if (!cfg.supervisor_state_mask[11]) w2[7] = 1'b0;
            if (!cfg.cr4_allowed[16]) w1[0]  = 1'b0;
            if (!cfg.cr4_allowed[20]) w1[7]  = 1'b0;
            if (!cfg.cr4_allowed[21]) w1[20] = 1'b0;
            if (!cfg.cr4_allowed[11]) w2[2]  = 1'b0;
          end
        end
        LEAF_EXT_FEAT: begin
          w2[2] = svm_ok;
          if (!avx_ok) begin
            w2[11] = 1'b0;
            w2[16] = 1'b0;
          end
        end
        LEAF_SVM: begin
          if (!svm_ok) begin
            zero = 1'b1;
          end else begin
            w0 = 32'd1;
            w1 = cfg.asid_count;
            w2 = '0;
            w3 = cfg.svm_feature_bits & SVM_FEATURE_ALLOW_MASK;
          end
        end
        LEAF_ADDR_SIZE: begin
          if (!addr_ok) begin
            st   = ST_REJECT;
            zero = 1'b1;
          end else begin
            w0 = (w0 & ADDR_KEEP_MASK) | {16'd0, LINEAR_BITS, cfg.phys_addr_bits};
          end
        end
        LEAF_MEM_ENC: begin
          zero = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign r.status  = st;
  assign r.out_eax = zero ? 32'd0 : w0;
  assign r.out_ebx = zero ? 32'd0 : w1;
  assign r.out_ecx = zero ? 32'd0 : w2;
  assign r.out_edx = zero ? 32'd0 : w3;

endmodule

### rtl/nested_cpuid_feature_filter.sv
// top level: query register, filter logic and result register
// a word accepted on s_axis is held in the query register, then in the result register, before it appears on m_axis
// throughput: one query per cycle while m_axis is ready; the query register refills as the result register drains
// a stalled m_axis holds the result stage and, once the query stage is full, holds it too and backs s_axis_tready off
// rst (synchronous, active high) empties both stages and returns the policy
// registers to their defaults (all zero, phys_addr_bits 48)
module nested_cpuid_feature_filter
  import ncff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // leaf, subleaf, guest_cr4, raw_eax, raw_ebx, raw_ecx, raw_edx
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, out_eax, out_ebx, out_ecx, out_edx, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_data
);

  cfg_t    cfg;
  query_t  q_in;
  query_t  query;
  logic    query_valid;
  result_t res_next;
  result_t res;
  logic    res_valid;
  logic    advance;

  ncff_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign q_in.leaf      = s_axis_tdata[31:0];
  assign q_in.subleaf   = s_axis_tdata[63:32];
  assign q_in.guest_cr4 = s_axis_tdata[127:64];
  assign q_in.raw_eax   = s_axis_tdata[159:128];
  assign q_in.raw_ebx   = s_axis_tdata[191:160];
  assign q_in.raw_ecx   = s_axis_tdata[223:192];
  assign q_in.raw_edx   = s_axis_tdata[255:224];

  // query moves on when the result register is empty or being drained
  assign advance       = !res_valid || m_axis_tready;
  assign s_axis_tready = !query_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else if (s_axis_tready) begin
      query_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      query <= q_in;
    end
  end

  ncff_filter u_filter (
    .cfg (cfg),
    .q   (query),
    .r   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && query_valid) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {6'd0, res.out_edx, res.out_ecx, res.out_ebx, res.out_eax, res.status};

  // an empty query stage always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !query_valid |-> s_axis_tready)
    else $error("input stalled with empty query stage");

  // a held query keeps its contents while the result stage is blocked
  a_query_held: assert property (@(posedge clk) disable iff (rst)
    (query_valid && res_valid && !m_axis_tready) |=> (query_valid && $stable(query)))
    else $error("query lost while result stalled");

  // a query that reaches a drained result stage shows up as a result next cycle
  a_query_to_result: assert property (@(posedge clk) disable iff (rst)
    (query_valid && advance) |=> res_valid)
    else $error("query dropped between stages");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_OK || res.status == ST_REJECT || res.status == ST_XSTATE))
    else $error("undefined status code");

endmodule
